// ----- rtl/clcd_pkg.sv -----
package clcd_pkg;

  // Request kinds as they arrive on the input channel
  typedef enum logic [2:0] {
    KIND_INIT   = 3'd0,
    KIND_INSTR  = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_TEXT   = 3'd3,
    KIND_NUMBER = 3'd4
  } req_kind_t;

  // Pin-level event codes on the result channel
  typedef enum logic [1:0] {
    ACT_PORT_LOW = 2'd0,
    ACT_WAIT     = 2'd1,
    ACT_NIBBLE   = 2'd2,
    ACT_BUSY     = 2'd3
  } action_t;

  // Classified work handed from front to back
  typedef enum logic [1:0] {
    JOB_INIT   = 2'd0,
    JOB_BYTE   = 2'd1,
    JOB_NUMBER = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    PH_HI   = 2'd0,
    PH_LO   = 2'd1,
    PH_BUSY = 2'd2
  } phase_t;

  localparam int MAG_W       = 14;
  localparam int DELAY_W     = 15;
  localparam int INIT_STEP_W = 5;
  localparam int NUM_DIGITS  = 4;

  localparam logic [INIT_STEP_W-1:0] INIT_LAST_STEP = 5'd21;
  localparam logic [MAG_W-1:0]       MAG_MAX        = 14'd9999;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CMD_LINE2    = 8'hC0;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [3:0] DIGIT_HI     = 4'h3;
  localparam logic       CMD_DDRAM    = 1'b1;

  // Byte slots of a number print: cursor command, sign, four digits
  localparam logic [2:0] BYTE_CMD       = 3'd0;
  localparam logic [2:0] BYTE_SIGN      = 3'd1;
  localparam logic [2:0] BYTE_DIG_FIRST = 3'd2;
  localparam logic [2:0] BYTE_DIG_LAST  = 3'd5;

  localparam logic [MAG_W-1:0] DIGIT_WEIGHT [NUM_DIGITS] = '{14'd1000, 14'd100, 14'd10, 14'd1};

  typedef struct packed {
    job_kind_t        kind;
    logic [7:0]       byte_val;
    logic             rs;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [6:0]       loc;
  } job_t;

  typedef struct packed {
    action_t            action;
    logic [3:0]         nibble;
    logic               rs;
    logic [DELAY_W-1:0] delay_us;
  } event_t;

  // Power-up wake-up and set-up sequence, one event per step
  function automatic event_t init_event(input logic [INIT_STEP_W-1:0] step);
    event_t ev;
    ev.action   = ACT_BUSY;
    ev.nibble   = 4'h0;
    ev.rs       = 1'b0;
    ev.delay_us = '0;
    case (step)
      5'd0:  ev.action = ACT_PORT_LOW;
      5'd1:  begin ev.action = ACT_WAIT;   ev.delay_us = 15'd20000; end
      5'd2:  begin ev.action = ACT_NIBBLE; ev.nibble = 4'h3; end
      5'd3:  begin ev.action = ACT_WAIT;   ev.delay_us = 15'd5000; end
      5'd4:  begin ev.action = ACT_NIBBLE; ev.nibble = 4'h3; end
      5'd5:  begin ev.action = ACT_WAIT;   ev.delay_us = 15'd120; end
      5'd6:  begin ev.action = ACT_NIBBLE; ev.nibble = 4'h3; end
      5'd8:  begin ev.action = ACT_NIBBLE; ev.nibble = 4'h2; end
      5'd10: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h2; end
      5'd11: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h8; end
      5'd13: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h0; end
      5'd14: begin ev.action = ACT_NIBBLE; ev.nibble = 4'hC; end
      5'd16: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h0; end
      5'd17: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h1; end
      5'd19: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h0; end
      5'd20: begin ev.action = ACT_NIBBLE; ev.nibble = 4'h6; end
      default: ev.action = ACT_BUSY;
    endcase
    return ev;
  endfunction

endpackage

// ----- rtl/clcd_front.sv -----
module clcd_front import clcd_pkg::*; (
  input  logic              in_valid,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_byte_value,
  input  logic signed [14:0] in_number,
  input  logic [6:0]        in_location,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output job_t              push_job
);

  logic        known;
  logic [14:0] abs_v;

  assign in_stall = q_full;

  always_comb begin
    known             = 1'b1;
    push_job.kind     = JOB_BYTE;
    push_job.byte_val = in_byte_value;
    push_job.rs       = 1'b0;
    push_job.neg      = in_number[14];
    push_job.loc      = in_location;
    abs_v             = in_number[14] ? 15'(-in_number) : 15'(in_number);
    push_job.mag      = (abs_v > 15'(MAG_MAX)) ? MAG_MAX : abs_v[MAG_W-1:0];
    case (req_kind_t'(in_kind))
      KIND_INIT:   push_job.kind = JOB_INIT;
      KIND_INSTR:  push_job.rs   = 1'b0;
      KIND_DATA:   push_job.rs   = 1'b1;
      KIND_TEXT: begin
        // newline moves the cursor to the second line
        if (in_byte_value == CHAR_NEWLINE) begin
          push_job.byte_val = CMD_LINE2;
          push_job.rs       = 1'b0;
        end else begin
          push_job.rs = 1'b1;
        end
      end
      KIND_NUMBER: push_job.kind = JOB_NUMBER;
      default:     known = 1'b0;
    endcase
  end

  // unknown kinds are taken and dropped
  assign push = in_valid && !q_full && known;

endmodule

// ----- rtl/clcd_fifo.sv -----
module clcd_fifo import clcd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output job_t q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/clcd_back.sv -----
module clcd_back import clcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_action,
  output logic [3:0]         out_nibble,
  output logic               out_reg_select,
  output logic [DELAY_W-1:0] out_delay_us,
  output logic               out_last
);

  logic                   active_r, active_nxt;
  job_t                   job_r, job_nxt;
  logic [INIT_STEP_W-1:0] step_r, step_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [2:0]             bidx_r, bidx_nxt;
  logic [MAG_W-1:0]       rem_r, rem_nxt;
  logic [3:0]             digit_r, digit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  event_t                 ev_r;
  logic                   last_r;

  logic             out_free, emit, ev_last;
  event_t           ev;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic [1:0]       wsel;
  logic [3:0]       dig_c [NUM_DIGITS];
  logic [MAG_W-1:0] sub_c [NUM_DIGITS];

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = active_r && out_free;
  assign q_pop    = q_valid && (!active_r || (emit && ev_last));

  // byte currently being sent
  always_comb begin
    cur_byte = job_r.byte_val;
    cur_rs   = job_r.rs;
    if (job_r.kind == JOB_NUMBER) begin
      priority case (bidx_r)
        BYTE_CMD: begin
          cur_byte = {CMD_DDRAM, job_r.loc};
          cur_rs   = 1'b0;
        end
        BYTE_SIGN: begin
          cur_byte = CHAR_MINUS;
          cur_rs   = 1'b1;
        end
        default: begin
          cur_byte = {DIGIT_HI, digit_r};
          cur_rs   = 1'b1;
        end
      endcase
    end
  end

  // event and end-of-request flag
  always_comb begin
    ev.action   = ACT_BUSY;
    ev.nibble   = 4'h0;
    ev.rs       = 1'b0;
    ev.delay_us = '0;
    ev_last     = 1'b0;
    if (job_r.kind == JOB_INIT) begin
      ev      = init_event(step_r);
      ev_last = (step_r == INIT_LAST_STEP);
    end else begin
      unique case (phase_r)
        PH_HI: begin
          ev.action = ACT_NIBBLE;
          ev.nibble = cur_byte[7:4];
          ev.rs     = cur_rs;
        end
        PH_LO: begin
          ev.action = ACT_NIBBLE;
          ev.nibble = cur_byte[3:0];
          ev.rs     = cur_rs;
        end
        default: begin
          ev.action = ACT_BUSY;
          ev_last   = (job_r.kind == JOB_BYTE) || (bidx_r == BYTE_DIG_LAST);
        end
      endcase
    end
  end

  // one decimal digit per byte: compare against multiples of its weight
  assign wsel = 2'(bidx_r - BYTE_DIG_FIRST);

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig_c[i] = 4'd0;
      sub_c[i] = '0;
      for (int k = 1; k <= 9; k++) begin
        if (rem_r >= MAG_W'(k * DIGIT_WEIGHT[i])) begin
          dig_c[i] = 4'(k);
          sub_c[i] = MAG_W'(k * DIGIT_WEIGHT[i]);
        end
      end
    end
  end

  always_comb begin
    active_nxt    = active_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    bidx_nxt      = bidx_r;
    rem_nxt       = rem_r;
    digit_nxt     = digit_r;
    out_valid_nxt = out_free ? emit : out_valid_r;

    if (q_pop) begin
      active_nxt = 1'b1;
      job_nxt    = q_job;
      step_nxt   = '0;
      phase_nxt  = PH_HI;
      bidx_nxt   = BYTE_CMD;
      rem_nxt    = q_job.mag;
    end else if (emit) begin
      if (ev_last) begin
        active_nxt = 1'b0;
      end
      step_nxt = step_r + 1'b1;
      unique case (phase_r)
        PH_HI: begin
          phase_nxt = PH_LO;
          if (job_r.kind == JOB_NUMBER && bidx_r >= BYTE_DIG_FIRST) begin
            digit_nxt = dig_c[wsel];
            rem_nxt   = rem_r - sub_c[wsel];
          end
        end
        PH_LO: phase_nxt = PH_BUSY;
        default: begin
          phase_nxt = PH_HI;
          // skip the sign byte for a non-negative value
          bidx_nxt  = (bidx_r == BYTE_CMD && !job_r.neg) ? BYTE_DIG_FIRST : bidx_r + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    step_r  <= step_nxt;
    phase_r <= phase_nxt;
    bidx_r  <= bidx_nxt;
    rem_r   <= rem_nxt;
    digit_r <= digit_nxt;
    if (emit) begin
      ev_r   <= ev;
      last_r <= ev_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = ev_r.action;
  assign out_nibble     = ev_r.nibble;
  assign out_reg_select = ev_r.rs;
  assign out_delay_us   = ev_r.delay_us;
  assign out_last       = last_r;

endmodule

// ----- rtl/char_lcd_4bit_command_sequencer_top.sv -----
// Character LCD command sequencer, 4-bit bus.
// Input channel (in_valid / in_stall): one request per transaction: power-up
// init, instruction byte, data byte, text character or a signed number printed
// at a cursor location. Kinds 5 to 7 are taken and produce nothing.
// Output channel (out_valid / out_stall): one pin event per transaction: port
// low, timed wait, nibble with enable pulse, or busy wait; out_last marks the
// final event of a request.
// A taken request goes into the queue, then the back end's job register, and its
// first event is registered on the output. Throughput: one event per cycle while
// out_stall is low; 3 events per byte, 15 or 18 for a number, 22 for init. The event
// sequencer in the back end sets this figure; a request queue of QUEUE_DEPTH
// entries lets new requests in while earlier ones are still being played out.
// Number digits are produced one per byte by a compare-and-subtract step.
// Reset (rst_n low, synchronous) empties the queue and drops any event in
// progress. A stalled output holds its event; once the queue fills, in_stall
// rises and holds the sender.
module char_lcd_4bit_command_sequencer_top import clcd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_byte_value,
  input  logic signed [14:0] in_number,
  input  logic [6:0]         in_location,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_action,
  output logic [3:0]         out_nibble,
  output logic               out_reg_select,
  output logic [14:0]        out_delay_us,
  output logic               out_last
);

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, q_job;

  // classify requests and clamp numbers
  clcd_front u_front (
    .in_valid      (in_valid),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .in_location   (in_location),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (q_push),
    .push_job      (push_job)
  );

  // decouple request intake from event playout
  clcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // expand each job into pin events, one per cycle while the output is not stalled
  clcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_delay_us   (out_delay_us),
    .out_last       (out_last)
  );

endmodule

// ----- rtl/clcd_checker.sv -----
module clcd_checker import clcd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_action,
  input logic [3:0]  out_nibble,
  input logic        out_reg_select,
  input logic [14:0] out_delay_us,
  input logic        out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) && $stable(out_nibble)
      && $stable(out_reg_select) && $stable(out_delay_us) && $stable(out_last))
    else $error("stalled event changed");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event shown right after reset");

  a_nibble_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_NIBBLE |-> out_nibble == 4'h0 && !out_reg_select)
    else $error("nibble or select set on a non-nibble event");

  a_delay_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_WAIT |-> out_delay_us == '0)
    else $error("delay set on a non-wait event");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_action == ACT_BUSY)
    else $error("request ended on an event other than a busy wait");

endmodule

bind char_lcd_4bit_command_sequencer_top clcd_checker u_clcd_checker (.*);
